[hdl/sdmc_pkg.sv]
// Shared types, codes and sizes for the door stepper motion controller.
// No dependencies; every other file refers to this package by scoped names.

package sdmc_pkg;

    // Sizes of the design
    localparam int QUEUE_DEPTH = 10;
    localparam int STEP_BITS   = 24;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int ROT_W    = 24;
    localparam int HALF_W   = 16;
    localparam int DELAY_W  = 20;
    localparam int CSTEP_W  = 24;
    localparam int EDGE_W   = 16;
    localparam int POS_W    = 24;
    localparam int CODE_W   = 3;
    localparam int QOUT_W   = 4;
    localparam int CMP_W    = 32;

    // Zero-wait phases can cascade within one tick; this bounds the cascade
    localparam int CHAIN_LEN = 8;

    // Register file
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = 3;
    localparam logic [REGIDX_W-1:0] REG_OPEN_CLOSE_STEPS   = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_MAX_HOMING_STEPS   = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_HOMING_EDGE_STEPS  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_HOMING_HALF_PERIOD = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_SETTLE_TICKS       = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_OPEN_HALF_PERIOD   = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_CLOSE_HALF_PERIOD  = 3'd6;

    localparam logic [CSTEP_W-1:0] RST_OPEN_CLOSE_STEPS   = 24'd1000;
    localparam logic [CSTEP_W-1:0] RST_MAX_HOMING_STEPS   = 24'd4000;
    localparam logic [EDGE_W-1:0]  RST_HOMING_EDGE_STEPS  = 16'd50;
    localparam logic [HALF_W-1:0]  RST_HOMING_HALF_PERIOD = 16'd300;
    localparam logic [DELAY_W-1:0] RST_SETTLE_TICKS       = 20'd10000;
    localparam logic [HALF_W-1:0]  RST_OPEN_HALF_PERIOD   = 16'd120;
    localparam logic [HALF_W-1:0]  RST_CLOSE_HALF_PERIOD  = 16'd120;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_OPEN   = 3'd1,
        ACT_CLOSE  = 3'd2,
        ACT_HOME   = 3'd3,
        ACT_ROTATE = 3'd4
    } t_action;

    typedef enum logic [CODE_W-1:0] {
        DOOR_UNKNOWN = 3'd0,
        DOOR_HOMING  = 3'd1,
        DOOR_OPEN    = 3'd2,
        DOOR_CLOSING = 3'd3,
        DOOR_CLOSED  = 3'd4,
        DOOR_OPENING = 3'd5
    } t_door;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE           = 3'd0,
        ERR_NOT_HOMED      = 3'd1,
        ERR_ALREADY_CLOSED = 3'd2,
        ERR_ALREADY_OPEN   = 3'd3,
        ERR_IN_MOTION      = 3'd4,
        ERR_QUEUE_FULL     = 3'd5
    } t_err;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_H_EN    = 4'd2,
        PH_H_TEST  = 4'd3,
        PH_H_LOW   = 4'd4,
        PH_B_EN    = 4'd5,
        PH_B_TEST  = 4'd6,
        PH_B_LOW   = 4'd7,
        PH_M_START = 4'd8,
        PH_M_EN    = 4'd9,
        PH_M_TEST  = 4'd10,
        PH_M_LOW   = 4'd11
    } t_phase;

    // One queued move
    typedef struct packed {
        logic                 homing;
        logic                 dir;
        logic [STEP_BITS-1:0] steps;
        logic [HALF_W-1:0]    half;
    } t_move_cmd;

    // Queue status toward the sequencer
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

    // Queue requests from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_req;

    // Input word as held in the input register
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                stall_req;
        logic [ROT_W-1:0]    rotate_steps;
        logic                rotate_dir;
        logic [HALF_W-1:0]   rotate_half_period;
    } t_in_word;

    // Result word as held in the result register
    typedef struct packed {
        logic                    step_out;
        logic                    enable_n;
        logic                    dir_out;
        logic [CODE_W-1:0]       door_state;
        logic signed [POS_W-1:0] position;
        logic [CODE_W-1:0]       error;
        logic                    busy_res;
        logic [QOUT_W-1:0]       queue_count;
    } t_res_word;

    // Wait length for a step half period; zero counts as one
    function automatic logic [DELAY_W-1:0] half_wait(logic [HALF_W-1:0] h);
        return (h == '0) ? DELAY_W'(1) : DELAY_W'(h);
    endfunction

endpackage

[hdl/sdmc_in_if.sv]
// Input channel of the door controller: valid/ready plus one command or tick word.
// Depends on sdmc_pkg for field widths.

interface sdmc_in_if;
    logic                            valid;
    logic                            ready;
    logic [sdmc_pkg::ACTION_W-1:0]   action;
    logic                            stall_req;
    logic [sdmc_pkg::ROT_W-1:0]      rotate_steps;
    logic                            rotate_dir;
    logic [sdmc_pkg::HALF_W-1:0]     rotate_half_period;

    modport source (
        output valid, action, stall_req, rotate_steps, rotate_dir, rotate_half_period,
        input  ready
    );
    modport sink (
        input  valid, action, stall_req, rotate_steps, rotate_dir, rotate_half_period,
        output ready
    );
endinterface

[hdl/sdmc_out_if.sv]
// Result channel of the door controller: valid/ready plus one status word.
// Depends on sdmc_pkg for field widths.

interface sdmc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               step_out;
    logic                               enable_n;
    logic                               dir_out;
    logic [sdmc_pkg::CODE_W-1:0]        door_state;
    logic signed [sdmc_pkg::POS_W-1:0]  position;
    logic [sdmc_pkg::CODE_W-1:0]        error;
    logic                               busy_res;
    logic [sdmc_pkg::QOUT_W-1:0]        queue_count;

    modport source (
        output valid, step_out, enable_n, dir_out, door_state, position, error,
               busy_res, queue_count,
        input  ready
    );
    modport sink (
        input  valid, step_out, enable_n, dir_out, door_state, position, error,
               busy_res, queue_count,
        output ready
    );
endinterface

[hdl/stepper_door_motion_controller.sv]
// Top level of the door stepper motion controller: input register, command
// checks, pin sequencer, door state tracking, result register and APB registers.
// Depends on sdmc_pkg, sdmc_in_if, sdmc_out_if and sdmc_queue.
//
//   port     | dir | handshake               | word
//   ---------+-----+-------------------------+-------------------------------------
//   i_cmd    | in  | valid/ready             | action, stall_req, rotate operands
//   o_res    | out | valid/ready             | pins, door state, position, error
//   APB      | in  | psel/penable, pready=1  | seven setup registers at 4*index
//
// One word is taken per clock when the result side keeps up; an accepted word
// is held in the input register, then makes one pass through the checks and the
// sequencer into the result register. A tick runs up to eight zero-wait phases
// of the sequencer in that single pass. Reset is synchronous and active low; it
// empties the queue and both registers. A stalled result holds in the result
// register while one more word waits in the input register.

module stepper_door_motion_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sdmc_in_if.sink                         i_cmd,
    sdmc_out_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdmc_pkg::PADDR_W-1:0]    paddr,
    input  logic [sdmc_pkg::PDATA_W-1:0]    pwdata,
    output logic [sdmc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int SB = sdmc_pkg::STEP_BITS;

    // Setup registers
    logic [sdmc_pkg::CSTEP_W-1:0]  r_open_close_steps;
    logic [sdmc_pkg::CSTEP_W-1:0]  r_max_homing_steps;
    logic [sdmc_pkg::EDGE_W-1:0]   r_homing_edge_steps;
    logic [sdmc_pkg::HALF_W-1:0]   r_homing_half_period;
    logic [sdmc_pkg::DELAY_W-1:0]  r_settle_ticks;
    logic [sdmc_pkg::HALF_W-1:0]   r_open_half_period;
    logic [sdmc_pkg::HALF_W-1:0]   r_close_half_period;
    logic [sdmc_pkg::REGIDX_W-1:0] reg_idx;
    logic                          reg_wr;

    // Input and result registers
    logic                 r_in_valid;
    sdmc_pkg::t_in_word   r_in;
    logic                 r_out_valid;
    sdmc_pkg::t_res_word  r_out;
    logic                 advance;
    sdmc_pkg::t_res_word  res_word;

    // Sequencer and door state
    sdmc_pkg::t_phase     r_phase,      n_phase;
    logic [SB-1:0]        r_step_count, n_step_count;
    logic [sdmc_pkg::DELAY_W-1:0] r_delay, n_delay;
    logic                 r_stalled,    n_stalled;
    sdmc_pkg::t_door      r_mode,       n_mode;
    logic [SB-1:0]        r_position,   n_position;
    logic                 r_pin_step,   n_pin_step;
    logic                 r_pin_en_n,   n_pin_en_n;
    logic                 r_pin_dir,    n_pin_dir;
    sdmc_pkg::t_move_cmd  r_cur_cmd,    n_cur_cmd;
    sdmc_pkg::t_err       res_error;

    // Queue
    sdmc_pkg::t_queue_req    q_req;
    sdmc_pkg::t_queue_req    q_want;
    sdmc_pkg::t_move_cmd     q_push_cmd;
    sdmc_pkg::t_move_cmd     q_head_cmd;
    sdmc_pkg::t_queue_status q_status;
    logic [sdmc_pkg::QCNT_W-1:0] n_qcount;

    // APB register write and read
    assign pready  = 1'b1;
    assign reg_idx = paddr[sdmc_pkg::REGIDX_W+1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_close_steps   <= sdmc_pkg::RST_OPEN_CLOSE_STEPS;
            r_max_homing_steps   <= sdmc_pkg::RST_MAX_HOMING_STEPS;
            r_homing_edge_steps  <= sdmc_pkg::RST_HOMING_EDGE_STEPS;
            r_homing_half_period <= sdmc_pkg::RST_HOMING_HALF_PERIOD;
            r_settle_ticks       <= sdmc_pkg::RST_SETTLE_TICKS;
            r_open_half_period   <= sdmc_pkg::RST_OPEN_HALF_PERIOD;
            r_close_half_period  <= sdmc_pkg::RST_CLOSE_HALF_PERIOD;
        end else if (reg_wr) begin
            unique case (reg_idx)
                sdmc_pkg::REG_OPEN_CLOSE_STEPS:
                    r_open_close_steps <= pwdata[sdmc_pkg::CSTEP_W-1:0];
                sdmc_pkg::REG_MAX_HOMING_STEPS:
                    r_max_homing_steps <= pwdata[sdmc_pkg::CSTEP_W-1:0];
                sdmc_pkg::REG_HOMING_EDGE_STEPS:
                    r_homing_edge_steps <= pwdata[sdmc_pkg::EDGE_W-1:0];
                sdmc_pkg::REG_HOMING_HALF_PERIOD:
                    r_homing_half_period <= pwdata[sdmc_pkg::HALF_W-1:0];
                sdmc_pkg::REG_SETTLE_TICKS:
                    r_settle_ticks <= pwdata[sdmc_pkg::DELAY_W-1:0];
                sdmc_pkg::REG_OPEN_HALF_PERIOD:
                    r_open_half_period <= pwdata[sdmc_pkg::HALF_W-1:0];
                sdmc_pkg::REG_CLOSE_HALF_PERIOD:
                    r_close_half_period <= pwdata[sdmc_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sdmc_pkg::REG_OPEN_CLOSE_STEPS:   prdata = sdmc_pkg::PDATA_W'(r_open_close_steps);
            sdmc_pkg::REG_MAX_HOMING_STEPS:   prdata = sdmc_pkg::PDATA_W'(r_max_homing_steps);
            sdmc_pkg::REG_HOMING_EDGE_STEPS:  prdata = sdmc_pkg::PDATA_W'(r_homing_edge_steps);
            sdmc_pkg::REG_HOMING_HALF_PERIOD: prdata = sdmc_pkg::PDATA_W'(r_homing_half_period);
            sdmc_pkg::REG_SETTLE_TICKS:       prdata = sdmc_pkg::PDATA_W'(r_settle_ticks);
            sdmc_pkg::REG_OPEN_HALF_PERIOD:   prdata = sdmc_pkg::PDATA_W'(r_open_half_period);
            sdmc_pkg::REG_CLOSE_HALF_PERIOD:  prdata = sdmc_pkg::PDATA_W'(r_close_half_period);
            default:                          prdata = '0;
        endcase
    end

    // Handshake: process the held word whenever the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.action             <= i_cmd.action;
            r_in.stall_req          <= i_cmd.stall_req;
            r_in.rotate_steps       <= i_cmd.rotate_steps;
            r_in.rotate_dir         <= i_cmd.rotate_dir;
            r_in.rotate_half_period <= i_cmd.rotate_half_period;
        end
    end

    // Command FIFO
    assign q_req.push = q_want.push && advance;
    assign q_req.pop  = q_want.pop && advance;

    sdmc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (q_req),
        .i_push_cmd (q_push_cmd),
        .o_head_cmd (q_head_cmd),
        .o_status   (q_status)
    );

    // Next state: command checks, or one tick of the sequencer
    always_comb begin : p_next
        sdmc_pkg::t_phase     ph;
        logic [SB-1:0]        sc;
        logic [sdmc_pkg::DELAY_W-1:0] dt;
        logic                 stall;
        sdmc_pkg::t_door      mode;
        logic [SB-1:0]        pos;
        logic                 st;
        logic                 en_n;
        logic                 dr;
        sdmc_pkg::t_move_cmd  cmd;
        logic                 run;
        logic [sdmc_pkg::DELAY_W-1:0] hh;

        ph    = r_phase;
        sc    = r_step_count;
        dt    = r_delay;
        stall = r_stalled;
        mode  = r_mode;
        pos   = r_position;
        st    = r_pin_step;
        en_n  = r_pin_en_n;
        dr    = r_pin_dir;
        cmd   = r_cur_cmd;
        run   = 1'b0;
        hh    = sdmc_pkg::half_wait(r_homing_half_period);

        res_error   = sdmc_pkg::ERR_NONE;
        q_want.push = 1'b0;
        q_want.pop  = 1'b0;
        q_push_cmd  = '0;

        unique case (r_in.action) inside
            sdmc_pkg::ACT_TICK: begin
                // Pick up the next queued move when idle
                if (ph == sdmc_pkg::PH_IDLE && !q_status.empty) begin
                    cmd        = q_head_cmd;
                    q_want.pop = 1'b1;
                    stall      = 1'b0;
                    ph         = sdmc_pkg::PH_START;
                    dt         = '0;
                end
                if (r_in.stall_req) begin
                    stall = 1'b1;
                end
                // Count down one microsecond
                if (ph != sdmc_pkg::PH_IDLE) begin
                    if (dt != '0) begin
                        dt = dt - sdmc_pkg::DELAY_W'(1);
                    end
                    run = (dt == '0);
                end
                // Run phases until one starts a wait or the move ends
                for (int k = 0; k < sdmc_pkg::CHAIN_LEN; k++) begin
                    if (run) begin
                        unique case (ph)
                            sdmc_pkg::PH_START: begin
                                sc = '0;
                                if (cmd.homing) begin
                                    dr  = 1'b0;
                                    ph  = sdmc_pkg::PH_H_EN;
                                    dt  = r_settle_ticks;
                                    run = (r_settle_ticks == '0);
                                end else begin
                                    ph = sdmc_pkg::PH_M_START;
                                end
                            end
                            sdmc_pkg::PH_H_EN: begin
                                en_n = 1'b0;
                                ph   = sdmc_pkg::PH_H_TEST;
                                dt   = r_settle_ticks;
                                run  = (r_settle_ticks == '0);
                            end
                            sdmc_pkg::PH_H_TEST: begin
                                if (!stall && (sdmc_pkg::CMP_W'(sc) <
                                               sdmc_pkg::CMP_W'(r_max_homing_steps))) begin
                                    st  = 1'b1;
                                    ph  = sdmc_pkg::PH_H_LOW;
                                    dt  = hh;
                                    run = 1'b0;
                                end else begin
                                    en_n = 1'b1;
                                    sc   = '0;
                                    if (stall) begin
                                        dr  = 1'b1;
                                        ph  = sdmc_pkg::PH_B_EN;
                                        dt  = r_settle_ticks;
                                        run = (r_settle_ticks == '0);
                                    end else begin
                                        mode = sdmc_pkg::DOOR_UNKNOWN;
                                        ph   = sdmc_pkg::PH_M_START;
                                    end
                                end
                            end
                            sdmc_pkg::PH_H_LOW: begin
                                st  = 1'b0;
                                sc  = sc + SB'(1);
                                ph  = sdmc_pkg::PH_H_TEST;
                                dt  = hh;
                                run = 1'b0;
                            end
                            sdmc_pkg::PH_B_EN: begin
                                en_n = 1'b0;
                                ph   = sdmc_pkg::PH_B_TEST;
                                dt   = r_settle_ticks;
                                run  = (r_settle_ticks == '0);
                            end
                            sdmc_pkg::PH_B_TEST: begin
                                if (sdmc_pkg::CMP_W'(sc) <
                                    sdmc_pkg::CMP_W'(r_homing_edge_steps)) begin
                                    st  = 1'b1;
                                    ph  = sdmc_pkg::PH_B_LOW;
                                    dt  = hh;
                                    run = 1'b0;
                                end else begin
                                    en_n = 1'b1;
                                    pos  = SB'(r_homing_edge_steps);
                                    mode = sdmc_pkg::DOOR_OPEN;
                                    sc   = '0;
                                    ph   = sdmc_pkg::PH_M_START;
                                end
                            end
                            sdmc_pkg::PH_B_LOW: begin
                                st  = 1'b0;
                                sc  = sc + SB'(1);
                                ph  = sdmc_pkg::PH_B_TEST;
                                dt  = hh;
                                run = 1'b0;
                            end
                            sdmc_pkg::PH_M_START: begin
                                dr  = cmd.dir;
                                sc  = '0;
                                ph  = sdmc_pkg::PH_M_EN;
                                dt  = r_settle_ticks;
                                run = (r_settle_ticks == '0);
                            end
                            sdmc_pkg::PH_M_EN: begin
                                en_n = 1'b0;
                                ph   = sdmc_pkg::PH_M_TEST;
                                dt   = r_settle_ticks;
                                run  = (r_settle_ticks == '0);
                            end
                            sdmc_pkg::PH_M_TEST: begin
                                if (sc < cmd.steps) begin
                                    st  = 1'b1;
                                    ph  = sdmc_pkg::PH_M_LOW;
                                    dt  = sdmc_pkg::half_wait(cmd.half);
                                    run = 1'b0;
                                end else begin
                                    // Move done: disable and book the travel
                                    en_n = 1'b1;
                                    if (cmd.steps != '0) begin
                                        if (!cmd.dir) begin
                                            mode = sdmc_pkg::DOOR_OPEN;
                                            pos  = pos - sc;
                                        end else begin
                                            mode = sdmc_pkg::DOOR_CLOSED;
                                            pos  = pos + sc;
                                        end
                                    end
                                    ph  = sdmc_pkg::PH_IDLE;
                                    run = 1'b0;
                                end
                            end
                            sdmc_pkg::PH_M_LOW: begin
                                st  = 1'b0;
                                sc  = sc + SB'(1);
                                ph  = sdmc_pkg::PH_M_TEST;
                                dt  = sdmc_pkg::half_wait(cmd.half);
                                run = 1'b0;
                            end
                            default: begin
                                ph  = sdmc_pkg::PH_IDLE;
                                run = 1'b0;
                            end
                        endcase
                    end
                end
            end
            sdmc_pkg::ACT_OPEN, sdmc_pkg::ACT_CLOSE: begin
                // Check door state in priority order, then the queue
                if (mode == sdmc_pkg::DOOR_UNKNOWN) begin
                    res_error = sdmc_pkg::ERR_NOT_HOMED;
                end else if (mode == sdmc_pkg::DOOR_CLOSING ||
                             mode == sdmc_pkg::DOOR_OPENING) begin
                    res_error = sdmc_pkg::ERR_IN_MOTION;
                end else if (r_in.action == sdmc_pkg::ACT_OPEN &&
                             mode == sdmc_pkg::DOOR_OPEN) begin
                    res_error = sdmc_pkg::ERR_ALREADY_OPEN;
                end else if (r_in.action == sdmc_pkg::ACT_CLOSE &&
                             mode == sdmc_pkg::DOOR_CLOSED) begin
                    res_error = sdmc_pkg::ERR_ALREADY_CLOSED;
                end else if (q_status.full) begin
                    res_error = sdmc_pkg::ERR_QUEUE_FULL;
                end else begin
                    q_want.push      = 1'b1;
                    q_push_cmd.steps = SB'(r_open_close_steps);
                    if (r_in.action == sdmc_pkg::ACT_OPEN) begin
                        q_push_cmd.dir  = 1'b0;
                        q_push_cmd.half = r_open_half_period;
                        mode            = sdmc_pkg::DOOR_OPENING;
                    end else begin
                        q_push_cmd.dir  = 1'b1;
                        q_push_cmd.half = r_close_half_period;
                        mode            = sdmc_pkg::DOOR_CLOSING;
                    end
                end
            end
            sdmc_pkg::ACT_HOME: begin
                if (q_status.full) begin
                    res_error = sdmc_pkg::ERR_QUEUE_FULL;
                end else begin
                    q_want.push       = 1'b1;
                    q_push_cmd.homing = 1'b1;
                    q_push_cmd.half   = r_homing_half_period;
                end
            end
            sdmc_pkg::ACT_ROTATE: begin
                if (q_status.full) begin
                    res_error = sdmc_pkg::ERR_QUEUE_FULL;
                end else begin
                    q_want.push      = 1'b1;
                    q_push_cmd.dir   = r_in.rotate_dir;
                    q_push_cmd.steps = SB'(r_in.rotate_steps);
                    q_push_cmd.half  = r_in.rotate_half_period;
                    mode = r_in.rotate_dir ? sdmc_pkg::DOOR_CLOSING : sdmc_pkg::DOOR_OPENING;
                end
            end
            default: ;
        endcase

        n_phase      = ph;
        n_step_count = sc;
        n_delay      = dt;
        n_stalled    = stall;
        n_mode       = mode;
        n_position   = pos;
        n_pin_step   = st;
        n_pin_en_n   = en_n;
        n_pin_dir    = dr;
        n_cur_cmd    = cmd;
    end

    // Result word from the updated state
    always_comb begin
        n_qcount = q_status.count + sdmc_pkg::QCNT_W'(q_want.push)
                 - sdmc_pkg::QCNT_W'(q_want.pop);
        res_word.step_out    = n_pin_step;
        res_word.enable_n    = n_pin_en_n;
        res_word.dir_out     = n_pin_dir;
        res_word.door_state  = n_mode;
        res_word.position    = sdmc_pkg::POS_W'(n_position);
        res_word.error       = res_error;
        res_word.busy_res    = (n_phase != sdmc_pkg::PH_IDLE);
        res_word.queue_count = sdmc_pkg::QOUT_W'(n_qcount);
    end

    // Commit state when the word is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sdmc_pkg::PH_IDLE;
            r_step_count <= '0;
            r_delay      <= '0;
            r_stalled    <= 1'b0;
            r_mode       <= sdmc_pkg::DOOR_UNKNOWN;
            r_position   <= '0;
            r_pin_step   <= 1'b0;
            r_pin_en_n   <= 1'b1;
            r_pin_dir    <= 1'b0;
            r_cur_cmd    <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_step_count <= n_step_count;
            r_delay      <= n_delay;
            r_stalled    <= n_stalled;
            r_mode       <= n_mode;
            r_position   <= n_position;
            r_pin_step   <= n_pin_step;
            r_pin_en_n   <= n_pin_en_n;
            r_pin_dir    <= n_pin_dir;
            r_cur_cmd    <= n_cur_cmd;
        end
    end

    // Result register: load on process, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res_word;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.step_out    = r_out.step_out;
    assign o_res.enable_n    = r_out.enable_n;
    assign o_res.dir_out     = r_out.dir_out;
    assign o_res.door_state  = r_out.door_state;
    assign o_res.position    = r_out.position;
    assign o_res.error       = r_out.error;
    assign o_res.busy_res    = r_out.busy_res;
    assign o_res.queue_count = r_out.queue_count;

endmodule

[hdl/sdmc_queue.sv]
// Command FIFO of the door controller: circular register store with head and fill.
// Depends on sdmc_pkg for the move type, status struct and depth.

module sdmc_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sdmc_pkg::t_queue_req    i_req,
    input  sdmc_pkg::t_move_cmd     i_push_cmd,
    output sdmc_pkg::t_move_cmd     o_head_cmd,
    output sdmc_pkg::t_queue_status o_status
);

    localparam int SUM_W = sdmc_pkg::QCNT_W + 1;

    sdmc_pkg::t_move_cmd                r_mem [sdmc_pkg::QUEUE_DEPTH];
    logic [sdmc_pkg::QIDX_W-1:0]        r_head;
    logic [sdmc_pkg::QCNT_W-1:0]        r_fill;
    logic [sdmc_pkg::QIDX_W-1:0]        n_head;
    logic [sdmc_pkg::QCNT_W-1:0]        n_fill;
    logic [SUM_W-1:0]                   tail_sum;
    logic [sdmc_pkg::QIDX_W-1:0]        tail;

    // Tail slot: head plus fill, wrapped once
    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
        if (tail_sum >= SUM_W'(sdmc_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(sdmc_pkg::QUEUE_DEPTH);
        end
        tail = sdmc_pkg::QIDX_W'(tail_sum);
    end

    // Advance head and fill count
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_req.pop) begin
            if (r_head == sdmc_pkg::QIDX_W'(sdmc_pkg::QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + sdmc_pkg::QIDX_W'(1);
            end
        end
        n_fill = r_fill + sdmc_pkg::QCNT_W'(i_req.push) - sdmc_pkg::QCNT_W'(i_req.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Store a pushed word at the tail
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[tail] <= i_push_cmd;
        end
    end

    assign o_head_cmd     = r_mem[r_head];
    assign o_status.full  = (r_fill == sdmc_pkg::QCNT_W'(sdmc_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_status.count = r_fill;

endmodule
